// ===== rtl/pve_pkg.sv =====
// ----------------------------------------------------------------------------
// Pose velocity estimator package
// Shared widths, constants and the arctangent table.
// ----------------------------------------------------------------------------
package pve_pkg;

  localparam int SpeedW = 23;
  localparam int PosW = 32;
  localparam int OrientW = 16;
  localparam int TimeW = 48;
  localparam int RateW = 32;
  localparam int CordicSteps = 17;
  localparam logic [SpeedW-1:0] SpeedLimitReset = 23'd524288;
  localparam logic [19:0] UsPerS = 20'd1000000;

  typedef logic [SpeedW-1:0] speed_t;

  // Arctangent of two to the minus i, Q16.16 radians, rounded to nearest.
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] a;
    begin
      unique case (i)
        5'd0: a = 17'd51472;
        5'd1: a = 17'd30386;
        5'd2: a = 17'd16055;
        5'd3: a = 17'd8150;
        5'd4: a = 17'd4091;
        5'd5: a = 17'd2047;
        5'd6: a = 17'd1024;
        5'd7: a = 17'd512;
        5'd8: a = 17'd256;
        5'd9: a = 17'd128;
        5'd10: a = 17'd64;
        5'd11: a = 17'd32;
        5'd12: a = 17'd16;
        5'd13: a = 17'd8;
        5'd14: a = 17'd4;
        5'd15: a = 17'd2;
        5'd16: a = 17'd1;
        default: a = 17'd0;
      endcase
      return a;
    end
  endfunction

endpackage

// ===== rtl/pose_velocity_estimator.sv =====
// ----------------------------------------------------------------------------
// Pose velocity estimator
// Speed and yaw rate from consecutive timestamped poses.
// ----------------------------------------------------------------------------
// Usage: one pose is a transfer on the in_ channel (valid/ready). Every pose
// gives exactly one result transfer on the out_ channel: the held speed, yaw
// rate and stamp, with out_updated set when this pose refreshed them.
// The cfg_ port writes the speed clamp (unsigned Q16.16 m/s) at any edge with
// cfg_we high; write it only while the block is idle.
// Sequence: one sequencer walks every pose through a square root (16 steps),
// the yaw CORDIC (a load step and 17 steps), the distance square sum and its
// square root (34 steps), then, when time advances, up to two 68-step
// restoring divides. A pose runs both divides when it refreshes the held
// twist, the speed divide alone when the speed comes out zero and neither
// when there is no earlier pose or time does not advance; the shared root
// and divide unit yields one bit per cycle. in_ready stays low until the
// result has been taken, so a stalled receiver holds the block; the next
// pose can be taken once the sequencer is back in idle after the transfer.
// Synchronous reset clears the previous pose and held twist and restores the
// 8 m/s clamp.
// ----------------------------------------------------------------------------
module pose_velocity_estimator #(
  parameter int SpeedW = pve_pkg::SpeedW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [pve_pkg::PosW-1:0] in_pos_x,
  input  logic signed [pve_pkg::PosW-1:0] in_pos_y,
  input  logic signed [pve_pkg::PosW-1:0] in_pos_z,
  input  logic signed [pve_pkg::OrientW-1:0] in_orient_z,
  input  logic [pve_pkg::TimeW-1:0]       in_time_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_updated,
  output logic [SpeedW-1:0]               out_speed,
  output logic signed [pve_pkg::RateW-1:0] out_yaw_rate,
  output logic [pve_pkg::TimeW-1:0]       out_twist_stamp,
  input  logic                            cfg_we,
  input  logic [SpeedW-1:0]               cfg_speed_limit
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CSQ   = 4'd1;
  localparam logic [3:0] S_CROOT = 4'd2;
  localparam logic [3:0] S_CORD  = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_DROOT = 4'd6;
  localparam logic [3:0] S_SMUL  = 4'd7;
  localparam logic [3:0] S_SDIV  = 4'd8;
  localparam logic [3:0] S_RMUL  = 4'd9;
  localparam logic [3:0] S_RDIV  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r;
  logic [SpeedW-1:0] limit_r;
  logic have_prev_r;
  logic signed [31:0] px_r, py_r, pz_r, cx_r, cy_r, cz_r;
  logic signed [31:0] pyaw_r, cyaw_r;
  logic [47:0] ptime_r, ctime_r, dt_r;
  logic signed [15:0] q_r;
  logic [SpeedW-1:0] hspeed_r;
  logic signed [31:0] hrate_r;
  logic [47:0] hstamp_r;
  logic upd_r;

  // Shared datapath registers.
  logic [67:0] rad_r;     // radicand or dividend shift register
  logic [69:0] rem_r;     // remainder
  logic [68:0] acc_r;     // root or quotient
  logic [6:0] cnt_r;
  logic [1:0] idx_r;
  logic signed [35:0] cxv_r, cyv_r;
  logic signed [20:0] cz_acc_r;
  logic signed [32:0] d_r;
  logic neg_r;

  logic [69:0] trial, rem_sh;
  logic [65:0] sq;
  logic signed [32:0] ydiff;
  logic [32:0] ymag;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_updated = upd_r;
  assign out_speed = hspeed_r;
  assign out_yaw_rate = hrate_r;
  assign out_twist_stamp = hstamp_r;

  // One restoring root step: two radicand bits in, one root bit out.
  assign rem_sh = {rem_r[67:0], rad_r[67:66]};
  assign trial = {acc_r[67:0], 2'b01};
  assign sq = 66'(d_r[32] ? -d_r : d_r) * 66'(d_r[32] ? -d_r : d_r);

  // Yaw change and its magnitude for the rate divide.
  assign ydiff = 33'(cyaw_r) - 33'(pyaw_r);
  assign ymag = ydiff[32] ? 33'(-ydiff) : 33'(ydiff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= SpeedW'(pve_pkg::SpeedLimitReset);
      have_prev_r <= 1'b0;
      px_r <= '0; py_r <= '0; pz_r <= '0; pyaw_r <= '0; ptime_r <= '0;
      hspeed_r <= '0; hrate_r <= '0; hstamp_r <= '0;
      upd_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_speed_limit;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cx_r <= in_pos_x; cy_r <= in_pos_y; cz_r <= in_pos_z;
            q_r <= in_orient_z; ctime_r <= in_time_us;
            state_r <= S_CSQ;
          end
        end
        // Radicand for the quaternion cosine term, aligned to the top.
        S_CSQ: begin
          rad_r <= {32'(32'sd1073741824 - 32'(q_r) * 32'(q_r)), 36'd0};
          rem_r <= '0; acc_r <= '0; cnt_r <= 7'd0;
          state_r <= S_CROOT;
        end
        S_CROOT: begin
          rad_r <= rad_r << 2;
          if (rem_sh >= trial) begin
            rem_r <= rem_sh - trial; acc_r <= {acc_r[67:0], 1'b1};
          end else begin
            rem_r <= rem_sh; acc_r <= {acc_r[67:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd15) begin
            cnt_r <= 7'd0;
            state_r <= S_CORD;
          end
        end
        // Vectoring CORDIC, one rotation per cycle.
        S_CORD: begin
          if (cnt_r == 7'd0) begin
            cxv_r <= 36'(acc_r[15:0]) <<< 15;
            cyv_r <= 36'(q_r) <<< 15;
            cz_acc_r <= '0;
            cnt_r <= 7'd1;
          end else begin
            if (cyv_r > 0) begin
              cxv_r <= cxv_r + (cyv_r >>> (cnt_r[4:0] - 5'd1));
              cyv_r <= cyv_r - (cxv_r >>> (cnt_r[4:0] - 5'd1));
              cz_acc_r <= cz_acc_r + 21'(pve_pkg::atan_q16(cnt_r[4:0] - 5'd1));
            end else if (cyv_r < 0) begin
              cxv_r <= cxv_r - (cyv_r >>> (cnt_r[4:0] - 5'd1));
              cyv_r <= cyv_r + (cxv_r >>> (cnt_r[4:0] - 5'd1));
              cz_acc_r <= cz_acc_r - 21'(pve_pkg::atan_q16(cnt_r[4:0] - 5'd1));
            end
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'(pve_pkg::CordicSteps)) begin
              cnt_r <= 7'd0;
              idx_r <= 2'd0;
              rad_r <= '0;
              state_r <= S_DIFF;
            end
          end
        end
        // Squared differences summed one axis at a time: S_DIFF forms the difference, S_SQ adds its square.
        S_DIFF: begin
          cyaw_r <= 32'(cz_acc_r) <<< 1;
          unique case (idx_r)
            2'd0: d_r <= 33'(cx_r) - 33'(px_r);
            2'd1: d_r <= 33'(cy_r) - 33'(py_r);
            default: d_r <= 33'(cz_r) - 33'(pz_r);
          endcase
          state_r <= S_SQ;
        end
        S_SQ: begin
          rad_r <= rad_r + 68'(sq);
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'd2) begin
            rem_r <= '0; acc_r <= '0; cnt_r <= 7'd0;
            state_r <= S_DROOT;
          end else begin
            state_r <= S_DIFF;
          end
        end
        S_DROOT: begin
          rad_r <= rad_r << 2;
          if (rem_sh >= trial) begin
            rem_r <= rem_sh - trial; acc_r <= {acc_r[67:0], 1'b1};
          end else begin
            rem_r <= rem_sh; acc_r <= {acc_r[67:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd33) begin
            dt_r <= ctime_r - ptime_r;
            state_r <= (have_prev_r && ctime_r > ptime_r) ? S_SMUL : S_DONE;
          end
        end
        // Distance times one million, then divide by the time step.
        S_SMUL: begin
          rad_r <= 68'(acc_r[33:0] * 54'(pve_pkg::UsPerS));
          rem_r <= '0; acc_r <= '0; cnt_r <= 7'd0;
          state_r <= S_SDIV;
        end
        S_SDIV, S_RDIV: begin
          rad_r <= rad_r << 1;
          if ({rem_r[68:0], rad_r[67]} >= 70'(dt_r)) begin
            rem_r <= {rem_r[68:0], rad_r[67]} - 70'(dt_r);
            acc_r <= {acc_r[67:0], 1'b1};
          end else begin
            rem_r <= {rem_r[68:0], rad_r[67]};
            acc_r <= {acc_r[67:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd67) begin
            state_r <= (state_r == S_SDIV) ? S_RMUL : S_DONE;
          end
        end
        // Speed known: test for motion, store the clamped speed and stamp, then set up the rate divide.
        S_RMUL: begin
          if (acc_r[67:0] == '0) begin
            state_r <= S_DONE;
          end else begin
            hspeed_r <= (acc_r[67:0] > 68'(limit_r)) ? limit_r : acc_r[SpeedW-1:0];
            hstamp_r <= ctime_r;
            upd_r <= 1'b1;
            neg_r <= ydiff[32];
            rad_r <= 68'(53'(ymag) * 53'(pve_pkg::UsPerS));
            rem_r <= '0; acc_r <= '0; cnt_r <= 7'd0;
            state_r <= S_RDIV;
          end
        end
        // Store the pose; saturate the rate when a divide finished it.
        S_DONE: begin
          if (upd_r) begin
            if (neg_r) begin
              hrate_r <= (acc_r[67:0] > 68'h80000000) ? 32'sh80000000
                         : 32'(-acc_r[31:0]);
            end else begin
              hrate_r <= (acc_r[67:0] > 68'h7fffffff) ? 32'sh7fffffff
                         : acc_r[31:0];
            end
          end
          have_prev_r <= 1'b1;
          px_r <= cx_r; py_r <= cy_r; pz_r <= cz_r;
          pyaw_r <= cyaw_r; ptime_r <= ctime_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            upd_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^{acc_r[68], rem_r[69]};

endmodule

// ===== rtl/pve_checker.sv =====
// ----------------------------------------------------------------------------
// Pose velocity estimator checker
// Port-level properties of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module pve_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_updated,
  input logic [47:0] out_twist_stamp
);

  // A pose is never taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // A result stalled by the receiver holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_updated, out_twist_stamp}))
    else $error("result dropped");

  // After a pose transfer the block is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");

  // After a result transfer the block is ready again.
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not ready after result");

endmodule

bind pose_velocity_estimator pve_checker u_pve_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_updated(out_updated),
  .out_twist_stamp(out_twist_stamp)
);

// ===== tb/pose_velocity_estimator_checker.sv =====
// ----------------------------------------------------------------------------
// Pose velocity estimator checker
// Watches the pose, twist and clamp ports, predicts each twist transfer with
// its own fixed-point model of the estimator and compares field by field.
// ----------------------------------------------------------------------------
module pose_velocity_estimator_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [pve_pkg::PosW-1:0] in_pos_x,
  input  logic signed [pve_pkg::PosW-1:0] in_pos_y,
  input  logic signed [pve_pkg::PosW-1:0] in_pos_z,
  input  logic signed [pve_pkg::OrientW-1:0] in_orient_z,
  input  logic [pve_pkg::TimeW-1:0]       in_time_us,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_updated,
  input  logic [pve_pkg::SpeedW-1:0]      out_speed,
  input  logic signed [pve_pkg::RateW-1:0] out_yaw_rate,
  input  logic [pve_pkg::TimeW-1:0]       out_twist_stamp,
  input  logic                            cfg_we,
  input  logic [pve_pkg::SpeedW-1:0]      cfg_speed_limit,
  output int                              errors,
  output int                              pending,
  output int                              twists_seen,
  output int                              refreshes_seen
);

  typedef struct packed {
    logic                            updated;
    logic [pve_pkg::SpeedW-1:0]      speed;
    logic signed [pve_pkg::RateW-1:0] rate;
    logic [pve_pkg::TimeW-1:0]       stamp;
  } twist_t;

  localparam longint AtanTab [pve_pkg::CordicSteps] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1
  };

  twist_t twist_q[$];
  int err_cnt = 0, twist_cnt = 0, refresh_cnt = 0;

  // Model state, cleared by reset.
  logic [pve_pkg::SpeedW-1:0] clamp;
  logic                       primed;
  longint                     last_x, last_y, last_z, last_yaw;
  logic [pve_pkg::TimeW-1:0]  last_time;
  twist_t                     held;

  assign errors = err_cnt;
  assign pending = twist_q.size();
  assign twists_seen = twist_cnt;
  assign refreshes_seen = refresh_cnt;

  // Floor square root by the restoring digit method.
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] rem, root, trial;
    rem = 0;
    root = 0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 128'd3);
      root = root << 1;
      trial = (root << 1) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 128'd1;
      end
    end
    return root[63:0];
  endfunction

  // Yaw in Q16.16 radians from the quaternion z term, by vectoring CORDIC.
  function automatic longint yaw_from_qz(input logic signed [pve_pkg::OrientW-1:0] qz);
    longint q, c, x, y, z, xs, ys;
    q = qz;
    c = longint'(floor_sqrt(128'((longint'(1) << 30) - q * q)));
    x = c * 32768;
    y = q * 32768;
    z = 0;
    for (int i = 0; i < pve_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanTab[i];
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - AtanTab[i];
      end
    end
    return 2 * z;
  endfunction

  function automatic logic [127:0] square_of(input longint d);
    logic [127:0] a;
    a = (d < 0) ? 128'(-d) : 128'(d);
    return a * a;
  endfunction

  // Advance the model by one pose and return the twist it reports.
  function automatic twist_t next_twist(input longint x, input longint y,
                                        input longint z,
                                        input logic signed [pve_pkg::OrientW-1:0] qz,
                                        input logic [pve_pkg::TimeW-1:0] t);
    longint yaw, dt, rate;
    longint unsigned distance, spd;
    twist_t r;
    yaw = yaw_from_qz(qz);
    r = held;
    r.updated = 1'b0;
    if (primed && t > last_time) begin
      dt = longint'(t - last_time);
      distance = floor_sqrt(square_of(x - last_x) + square_of(y - last_y) +
                            square_of(z - last_z));
      spd = distance * 64'd1000000 / longint'(dt);
      if (spd != 0) begin
        rate = (yaw - last_yaw) * 1000000 / dt;
        if (rate > 64'sd2147483647) rate = 64'sd2147483647;
        if (rate < -64'sd2147483648) rate = -64'sd2147483648;
        if (spd > clamp) spd = clamp;
        held.speed = spd[pve_pkg::SpeedW-1:0];
        held.rate = rate[pve_pkg::RateW-1:0];
        held.stamp = t;
        r = held;
        r.updated = 1'b1;
      end
    end
    primed = 1'b1;
    last_x = x;
    last_y = y;
    last_z = z;
    last_yaw = yaw;
    last_time = t;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    err_cnt++;
    $display("MISMATCH %s: got %0d, expected %0d at twist %0d", what, got, want,
             twist_cnt);
  endtask

  // Track the clamp, predict on each pose transfer, compare each twist transfer.
  always @(posedge clk) begin
    twist_t w;
    if (!rst_n) begin
      clamp = pve_pkg::SpeedLimitReset;
      primed = 1'b0;
      last_x = 0;
      last_y = 0;
      last_z = 0;
      last_yaw = 0;
      last_time = '0;
      held = '0;
      twist_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        twist_cnt++;
        if (twist_q.size() == 0) begin
          report("twist transfer with nothing expected", 1, 0);
        end else begin
          w = twist_q.pop_front();
          if (out_updated) refresh_cnt++;
          if (out_updated !== w.updated) report("updated", out_updated, w.updated);
          if (out_speed !== w.speed) report("speed", out_speed, w.speed);
          if (out_yaw_rate !== w.rate) report("yaw_rate", out_yaw_rate, w.rate);
          if (out_twist_stamp !== w.stamp)
            report("twist_stamp", out_twist_stamp, w.stamp);
        end
      end
      if (in_valid && in_ready)
        twist_q.push_back(next_twist(in_pos_x, in_pos_y, in_pos_z, in_orient_z,
                                     in_time_us));
      if (cfg_we) clamp = cfg_speed_limit;
    end
  end

  // Anything still queued at the end of the run is a missing twist.
  task automatic flush_check();
    if (twist_q.size() != 0) begin
      report("twists never arrived", twist_q.size(), 0);
    end
  endtask

endmodule

// ===== tb/pose_velocity_estimator_tb.sv =====
// ----------------------------------------------------------------------------
// Pose velocity estimator testbench
// Drives directed and random pose streams through several clamp settings with
// bursty input and a stalling receiver; the checker predicts every twist.
// ----------------------------------------------------------------------------
module pose_velocity_estimator_tb;

  localparam int CycleLimit = 1500000;
  localparam int DrainCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [pve_pkg::PosW-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [pve_pkg::OrientW-1:0] in_orient_z = '0;
  logic [pve_pkg::TimeW-1:0] in_time_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_updated;
  logic [pve_pkg::SpeedW-1:0] out_speed;
  logic signed [pve_pkg::RateW-1:0] out_yaw_rate;
  logic [pve_pkg::TimeW-1:0] out_twist_stamp;
  logic cfg_we = 1'b0;
  logic [pve_pkg::SpeedW-1:0] cfg_speed_limit = '0;

  int errors, pending, twists_seen, refreshes_seen;
  int cycles = 0;
  int burst_left = 0;
  int poses_sent = 0;

  // Trajectory of the well-formed random walk.
  longint walk_x = 0, walk_y = 0, walk_z = 0;
  logic [pve_pkg::TimeW-1:0] walk_t = '0;

  always #6 clk = ~clk;

  pose_velocity_estimator dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_orient_z, .in_time_us, .out_valid, .out_ready, .out_updated, .out_speed,
    .out_yaw_rate, .out_twist_stamp, .cfg_we, .cfg_speed_limit
  );

  pose_velocity_estimator_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_orient_z, .in_time_us, .out_valid, .out_ready, .out_updated, .out_speed,
    .out_yaw_rate, .out_twist_stamp, .cfg_we, .cfg_speed_limit,
    .errors, .pending, .twists_seen, .refreshes_seen
  );

  // Receiver stalls follow one of four modes, taken in turn as the cycle count grows.
  always @(posedge clk) begin
    int mode;
    cycles <= cycles + 1;
    mode = (cycles / 200) % 4;
    case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(1, 0) == 1);
      2: out_ready <= ($urandom_range(7, 0) == 0);
      default: out_ready <= ((cycles % 32) >= 20);
    endcase
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("pose_velocity_estimator verification failed");
      $finish;
    end
  end

  // One pose transfer, with a random gap between bursts.
  task automatic send_pose(input longint x, input longint y, input longint z,
                           input logic signed [pve_pkg::OrientW-1:0] qz,
                           input logic [pve_pkg::TimeW-1:0] t);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x[pve_pkg::PosW-1:0];
    in_pos_y <= y[pve_pkg::PosW-1:0];
    in_pos_z <= z[pve_pkg::PosW-1:0];
    in_orient_z <= qz;
    in_time_us <= t;
    do @(posedge clk); while (!in_ready);
    poses_sent++;
  endtask

  // Clamp writes happen only with the block idle.
  task automatic write_limit(input logic [pve_pkg::SpeedW-1:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_speed_limit <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random pose: mostly a plausible walk, sometimes arbitrary noise.
  task automatic random_pose();
    int pick;
    logic signed [pve_pkg::OrientW-1:0] qz;
    pick = $urandom_range(99, 0);
    qz = pve_pkg::OrientW'($urandom);
    if (pick < 10) begin
      walk_x = longint'($signed($urandom));
      walk_y = longint'($signed($urandom));
      walk_z = longint'($signed($urandom));
      walk_t = pve_pkg::TimeW'({$urandom, $urandom});
    end else begin
      if (pick >= 15) begin
        walk_x += $signed($urandom_range(400000, 0)) - 200000;
        walk_y += $signed($urandom_range(400000, 0)) - 200000;
        walk_z += $signed($urandom_range(20000, 0)) - 10000;
      end
      if (pick < 13) walk_t = walk_t - $urandom_range(1000, 0);
      else if (pick < 88) walk_t = walk_t + $urandom_range(200000, 1);
      else walk_t = walk_t + $urandom_range(20, 1);
    end
    walk_x = longint'($signed(walk_x[pve_pkg::PosW-1:0]));
    walk_y = longint'($signed(walk_y[pve_pkg::PosW-1:0]));
    walk_z = longint'($signed(walk_z[pve_pkg::PosW-1:0]));
    send_pose(walk_x, walk_y, walk_z, qz, walk_t);
  endtask

  localparam longint PosMax = 2147483647;
  localparam longint PosMin = -2147483648;

  initial begin
    logic [pve_pkg::SpeedW-1:0] limits [4];
    limits = '{pve_pkg::SpeedLimitReset, '1, 23'd300000, 23'd1};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed poses at the reset clamp.
    send_pose(0, 0, 0, 0, 1000);                  // first pose
    send_pose(65536, 0, 0, 0, 1000);              // time equal
    send_pose(0, 65536, 0, 0, 500);               // time going back
    send_pose(0, 65536, 0, 100, 2000);            // no movement
    send_pose(65536, 65536, 0, 16384, 1002000);   // one metre per second
    send_pose(PosMax, PosMin, PosMax, -32768, 1002001); // clamp, rate floor
    send_pose(PosMin, PosMax, PosMin, 32767, 1002002);  // rate ceiling
    send_pose(PosMax, PosMax, PosMin, 0, 48'hFFFF_FFFF_FFFF); // latest time
    send_pose(0, 0, 0, -32768, 0);                // wrap back to zero time
    send_pose(-65536, 0, 3, -1, 7);

    // A zero clamp still records the update.
    write_limit('0);
    send_pose(0, 0, 0, 0, 10);
    send_pose(6553600, 0, 0, 8000, 20);
    send_pose(6553600, 1, 0, -8000, 1000020);

    // Random phases at several clamp settings.
    foreach (limits[p]) begin
      write_limit(limits[p]);
      repeat (450) random_pose();
    end
    write_limit(23'($urandom));
    repeat (60) random_pose();

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    checker_i.flush_check();
    @(posedge clk);
    $display("Sent %0d poses over six clamp settings; %0d twists checked,",
             poses_sent, twists_seen);
    $display("%0d of them refreshed the held twist.", refreshes_seen);
    if (errors == 0) begin
      $display("pose_velocity_estimator verification clean");
    end else begin
      $display("pose_velocity_estimator verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pve_pkg.sv
rtl/pose_velocity_estimator.sv
rtl/pve_checker.sv
tb/pose_velocity_estimator_checker.sv
tb/pose_velocity_estimator_tb.sv
